>>> rtl/cct_pkg.sv
// Package for the cell cycle capacity tester.
// Holds the transaction payload types, register indexes, sequencer states and
// the fixed arithmetic constants; it depends on nothing else.
package cct_pkg;

    localparam int VOLT_W  = 11;
    localparam int LOAD_W  = 10;
    localparam int TOTAL_W = 34;
    localparam int CAP_W   = 32;
    localparam int PCT_W   = 29;
    localparam int OUTT_W  = 24;
    localparam int CNT_W   = 6;
    localparam int PROD_W  = 17;
    localparam int QUO_W   = 32;

    localparam logic [OUTT_W-1:0] OUT_TIME_MAX = '1;

    // Floor divisions by 23 and 11 are exact for the value ranges met here.
    localparam logic [15:0] DIV23_MUL   = 16'd45591;
    localparam int          DIV23_SHIFT = 20;
    localparam logic [14:0] DIV11_MUL   = 15'd23832;
    localparam int          DIV11_SHIFT = 18;
    localparam logic [31:0] DIV15_MUL   = 32'h8888_8889;
    localparam int          DIV15_SHIFT = 35;

    localparam logic [6:0]        CAP_SCALE  = 7'd100;
    localparam logic [VOLT_W-1:0] VOLT_OFFSET = 11'd25;
    localparam logic [VOLT_W-1:0] MIN_RESET  = 11'd350;
    localparam logic [VOLT_W-1:0] MAX_RESET  = 11'd410;

    localparam logic [CNT_W-1:0] AVG_Q_BITS = 6'd10;
    localparam logic [CNT_W-1:0] CAP_Q_BITS = 6'd32;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CV = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CV = 1'b1;

    typedef struct packed {
        logic [VOLT_W-1:0] cell_centivolts;
    } t_in_item;

    typedef struct packed {
        logic              charging;
        logic [LOAD_W-1:0] load_current_ma;
        logic [CAP_W-1:0]  capacity_value;
        logic [PCT_W-1:0]  capacity_percent;
        logic [31:0]       cycles_done;
        logic [OUTT_W-1:0] charge_seconds;
        logic [OUTT_W-1:0] discharge_seconds;
    } t_out_item;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] count;
    } t_div_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_sts;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LOAD1,
        S_LOAD2,
        S_AVG_GO,
        S_AVG_WAIT,
        S_MUL1,
        S_MUL2,
        S_CAP_GO,
        S_CAP_WAIT,
        S_PCT,
        S_COMMIT
    } t_state;

endpackage

>>> rtl/cct_stream_ifs.sv
// Valid/ready channel interfaces for the input and result transactions.
// Depends on cct_pkg for the payload types.
interface cct_in_if;
    logic              valid;
    logic              ready;
    cct_pkg::t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface cct_out_if;
    logic               valid;
    logic               ready;
    cct_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/cell_cycle_capacity_tester.sv
// Top level of the cell cycle capacity tester: sequencer, accumulators and output register.
// Depends on cct_pkg, the channel interfaces and cct_divider.
//
// Each input transaction is one tick carrying the cell voltage. An ordinary tick
// goes through the states LOAD1 and LOAD2, where the load current is found by
// constant reciprocal multiplication, and then COMMIT, where the counters are
// updated and the result is registered. The tick that ends a discharge goes from
// LOAD2 through the bit-serial divider for the ten steps of the average current,
// the multiplications in MUL1 and MUL2, the divider again for the thirty-two steps
// of the capacity, and PCT before COMMIT. With no samples the average division
// is skipped, and a capacity that cannot fit in 32 bits skips the capacity
// division. Input is not accepted while a tick is in work; a finished result
// waits in the output register and the next tick may be taken meanwhile, but
// that tick cannot complete until the waiting result has left. Configuration
// writes are taken at any cycle and are meant to be issued only while the block
// is idle.
module cell_cycle_capacity_tester #(
    parameter int TIME_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    cct_in_if.sink                         i_in_chan,
    cct_out_if.source                      o_out_chan,
    input  logic                           i_cfg_we,
    input  logic [cct_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [cct_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DSR_W = (TIME_BITS > cct_pkg::VOLT_W) ? TIME_BITS : cct_pkg::VOLT_W;
    localparam int DVD_W = cct_pkg::PROD_W + TIME_BITS;
    localparam int EXT_W = (TIME_BITS > cct_pkg::OUTT_W) ? TIME_BITS : cct_pkg::OUTT_W;
    localparam logic [TIME_BITS-1:0] TIME_MAX = '1;

    cct_pkg::t_state r_state;
    cct_pkg::t_state n_state;

    logic [cct_pkg::VOLT_W-1:0]  r_min;
    logic [cct_pkg::VOLT_W-1:0]  r_max;

    logic                        r_phase;
    logic [TIME_BITS-1:0]        r_ctime;
    logic [TIME_BITS-1:0]        r_dtime;
    logic [cct_pkg::TOTAL_W-1:0] r_total;
    logic [TIME_BITS-1:0]        r_samples;
    logic [cct_pkg::CAP_W-1:0]   r_cap_hold;
    logic [cct_pkg::PCT_W-1:0]   r_pct_hold;
    logic [31:0]                 r_cycles;

    logic [cct_pkg::VOLT_W-1:0]  r_v;
    logic                        r_finish;
    logic [9:0]                  r_q23;
    logic [cct_pkg::LOAD_W-1:0]  r_load;
    logic [cct_pkg::LOAD_W-1:0]  r_avg;
    logic [cct_pkg::PROD_W-1:0]  r_prod;
    logic [DVD_W-1:0]            r_dvd;

    logic                        r_out_valid;
    cct_pkg::t_out_item          r_out;

    logic                        in_accept;
    logic                        commit_go;
    logic                        cap_sat;
    logic [cct_pkg::VOLT_W-1:0]  cap_div;
    logic [63:0]                 dvd_ext;
    logic [14:0]                 v10;
    logic [30:0]                 m23;
    logic [13:0]                 y10;
    logic [28:0]                 m11;
    logic [63:0]                 m15;

    cct_pkg::t_div_ctl           div_ctl;
    cct_pkg::t_div_sts           div_sts;
    logic [DSR_W-1:0]            div_divisor;
    logic [DSR_W-1:0]            div_rem_init;
    logic [cct_pkg::QUO_W-1:0]   div_bits_init;
    logic [cct_pkg::QUO_W-1:0]   div_quo;

    logic                        n_phase;
    logic [TIME_BITS-1:0]        n_ctime;
    logic [TIME_BITS-1:0]        n_dtime;
    logic [cct_pkg::TOTAL_W-1:0] n_total;
    logic [TIME_BITS-1:0]        n_samples;
    logic [31:0]                 n_cycles;
    logic [cct_pkg::LOAD_W-1:0]  n_load;
    logic [cct_pkg::TOTAL_W:0]   n_sum;
    logic [EXT_W-1:0]            n_ctime_ext;
    logic [EXT_W-1:0]            n_dtime_ext;

    cct_divider #(
        .DSR_W (DSR_W)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (div_ctl),
        .i_divisor   (div_divisor),
        .i_rem_init  (div_rem_init),
        .i_bits_init (div_bits_init),
        .o_sts       (div_sts),
        .o_quotient  (div_quo)
    );

    assign in_accept       = i_in_chan.valid && i_in_chan.ready;
    assign o_out_chan.valid = r_out_valid;
    assign o_out_chan.data  = r_out;

    always_comb begin
        v10     = {r_v, 3'b000} + {2'b00, r_v, 1'b0};
        m23     = 31'(v10) * 31'(cct_pkg::DIV23_MUL);
        y10     = {r_q23, 3'b000} + {2'b00, r_q23, 1'b0};
        m11     = 29'(y10) * 29'(cct_pkg::DIV11_MUL);
        m15     = 64'(r_cap_hold) * 64'(cct_pkg::DIV15_MUL);
        dvd_ext = 64'(r_dvd);
        cap_div = r_max - cct_pkg::VOLT_OFFSET;
        cap_sat = (r_max <= cct_pkg::VOLT_OFFSET) || (dvd_ext[63:32] >= 32'(cap_div));
    end

    always_comb begin
        if (r_state == cct_pkg::S_AVG_GO) begin
            div_divisor   = DSR_W'(r_samples);
            div_rem_init  = DSR_W'(r_total[cct_pkg::TOTAL_W-1:10]);
            div_bits_init = {r_total[9:0], 22'd0};
        end else begin
            div_divisor   = DSR_W'(cap_div);
            div_rem_init  = DSR_W'(dvd_ext[63:32]);
            div_bits_init = dvd_ext[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= cct_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state           = r_state;
        i_in_chan.ready   = 1'b0;
        div_ctl.start     = 1'b0;
        div_ctl.count     = (r_state == cct_pkg::S_AVG_GO) ? cct_pkg::AVG_Q_BITS :
                                                             cct_pkg::CAP_Q_BITS;
        commit_go         = 1'b0;
        case (r_state)
            cct_pkg::S_IDLE: begin
                i_in_chan.ready = 1'b1;
                if (i_in_chan.valid) begin
                    n_state = cct_pkg::S_LOAD1;
                end
            end
            cct_pkg::S_LOAD1: begin
                n_state = cct_pkg::S_LOAD2;
            end
            cct_pkg::S_LOAD2: begin
                n_state = r_finish ? cct_pkg::S_AVG_GO : cct_pkg::S_COMMIT;
            end
            cct_pkg::S_AVG_GO: begin
                if (r_samples == '0) begin
                    n_state = cct_pkg::S_MUL1;
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = cct_pkg::S_AVG_WAIT;
                end
            end
            cct_pkg::S_AVG_WAIT: begin
                if (div_sts.done) begin
                    n_state = cct_pkg::S_MUL1;
                end
            end
            cct_pkg::S_MUL1: begin
                n_state = cct_pkg::S_MUL2;
            end
            cct_pkg::S_MUL2: begin
                n_state = cct_pkg::S_CAP_GO;
            end
            cct_pkg::S_CAP_GO: begin
                if (cap_sat) begin
                    n_state = cct_pkg::S_PCT;
                end else begin
                    div_ctl.start = 1'b1;
                    n_state       = cct_pkg::S_CAP_WAIT;
                end
            end
            cct_pkg::S_CAP_WAIT: begin
                if (div_sts.done) begin
                    n_state = cct_pkg::S_PCT;
                end
            end
            cct_pkg::S_PCT: begin
                n_state = cct_pkg::S_COMMIT;
            end
            cct_pkg::S_COMMIT: begin
                if (!r_out_valid || o_out_chan.ready) begin
                    commit_go = 1'b1;
                    n_state   = cct_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = cct_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_phase   = r_phase;
        n_ctime   = r_ctime;
        n_dtime   = r_dtime;
        n_total   = r_total;
        n_samples = r_samples;
        n_cycles  = r_cycles;
        n_load    = '0;
        n_sum     = '0;
        if (r_finish) begin
            n_ctime  = '0;
            n_cycles = r_cycles + 32'd1;
            n_phase  = 1'b1;
        end
        if (n_phase && (r_v > r_max)) begin
            n_dtime   = '0;
            n_samples = '0;
            n_total   = '0;
            n_phase   = 1'b0;
        end
        if (!n_phase) begin
            if (n_dtime != TIME_MAX) begin
                n_dtime = n_dtime + 1'b1;
            end
            n_load = r_load;
            if ((r_load != '0) && (n_samples != TIME_MAX)) begin
                n_sum     = {1'b0, n_total} + (cct_pkg::TOTAL_W + 1)'(r_load);
                n_total   = n_sum[cct_pkg::TOTAL_W] ? '1 : n_sum[cct_pkg::TOTAL_W-1:0];
                n_samples = n_samples + 1'b1;
            end
        end else if (n_ctime != TIME_MAX) begin
            n_ctime = n_ctime + 1'b1;
        end
        n_ctime_ext = EXT_W'(n_ctime);
        n_dtime_ext = EXT_W'(n_dtime);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min <= cct_pkg::MIN_RESET;
            r_max <= cct_pkg::MAX_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                cct_pkg::CFG_MIN_CV: r_min <= i_cfg_data;
                cct_pkg::CFG_MAX_CV: r_max <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= 1'b0;
            r_ctime     <= '0;
            r_dtime     <= '0;
            r_total     <= '0;
            r_samples   <= '0;
            r_cap_hold  <= '0;
            r_pct_hold  <= '0;
            r_cycles    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (commit_go) begin
                r_out_valid <= 1'b1;
                r_phase     <= n_phase;
                r_ctime     <= n_ctime;
                r_dtime     <= n_dtime;
                r_total     <= n_total;
                r_samples   <= n_samples;
                r_cycles    <= n_cycles;
            end else if (o_out_chan.ready) begin
                r_out_valid <= 1'b0;
            end
            if ((r_state == cct_pkg::S_CAP_GO) && cap_sat) begin
                r_cap_hold <= '1;
            end else if ((r_state == cct_pkg::S_CAP_WAIT) && div_sts.done) begin
                r_cap_hold <= div_quo;
            end
            if (r_state == cct_pkg::S_PCT) begin
                r_pct_hold <= m15[cct_pkg::DIV15_SHIFT +: cct_pkg::PCT_W];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_v      <= i_in_chan.data.cell_centivolts;
            r_finish <= !r_phase && (i_in_chan.data.cell_centivolts <= r_min);
        end
        if (r_state == cct_pkg::S_LOAD1) begin
            r_q23 <= m23[cct_pkg::DIV23_SHIFT +: 10];
        end
        if (r_state == cct_pkg::S_LOAD2) begin
            r_load <= m11[cct_pkg::DIV11_SHIFT +: cct_pkg::LOAD_W];
        end
        if ((r_state == cct_pkg::S_AVG_GO) && (r_samples == '0)) begin
            r_avg <= '0;
        end else if ((r_state == cct_pkg::S_AVG_WAIT) && div_sts.done) begin
            r_avg <= div_quo[cct_pkg::LOAD_W-1:0];
        end
        if (r_state == cct_pkg::S_MUL1) begin
            r_prod <= cct_pkg::PROD_W'(r_avg * cct_pkg::CAP_SCALE);
        end
        if (r_state == cct_pkg::S_MUL2) begin
            r_dvd <= DVD_W'(r_prod) * DVD_W'(r_dtime);
        end
        if (commit_go) begin
            r_out.charging          <= n_phase;
            r_out.load_current_ma   <= n_load;
            r_out.capacity_value    <= r_cap_hold;
            r_out.capacity_percent  <= r_pct_hold;
            r_out.cycles_done       <= n_cycles;
            r_out.charge_seconds    <= (n_ctime_ext > EXT_W'(cct_pkg::OUT_TIME_MAX)) ?
                                       cct_pkg::OUT_TIME_MAX :
                                       n_ctime_ext[cct_pkg::OUTT_W-1:0];
            r_out.discharge_seconds <= (n_dtime_ext > EXT_W'(cct_pkg::OUT_TIME_MAX)) ?
                                       cct_pkg::OUT_TIME_MAX :
                                       n_dtime_ext[cct_pkg::OUTT_W-1:0];
        end
    end

endmodule

>>> rtl/cct_divider.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on cct_pkg for the control and status structs.
module cct_divider #(
    parameter int DSR_W = 24
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  cct_pkg::t_div_ctl       i_ctl,
    input  logic [DSR_W-1:0]        i_divisor,
    input  logic [DSR_W-1:0]        i_rem_init,
    input  logic [cct_pkg::QUO_W-1:0] i_bits_init,
    output cct_pkg::t_div_sts       o_sts,
    output logic [cct_pkg::QUO_W-1:0] o_quotient
);

    logic [DSR_W-1:0]          r_rem;
    logic [DSR_W-1:0]          r_div;
    logic [cct_pkg::QUO_W-1:0] r_bits;
    logic [cct_pkg::QUO_W-1:0] r_quo;
    logic [cct_pkg::CNT_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;
    logic [DSR_W:0]            trial;
    logic [DSR_W:0]            diff;
    logic                      qbit;

    always_comb begin
        trial = {r_rem, r_bits[cct_pkg::QUO_W-1]};
        diff  = trial - {1'b0, r_div};
        qbit  = (trial >= {1'b0, r_div});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_ctl.count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == cct_pkg::CNT_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_rem  <= i_rem_init;
            r_div  <= i_divisor;
            r_bits <= i_bits_init;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= qbit ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
            r_bits <= {r_bits[cct_pkg::QUO_W-2:0], 1'b0};
            r_quo  <= {r_quo[cct_pkg::QUO_W-2:0], qbit};
        end
    end

    assign o_sts.busy = r_busy;
    assign o_sts.done = r_done;
    assign o_quotient = r_quo;

endmodule

>>> rtl/cct_checker.sv
// Port-level checks for the cell cycle capacity tester, bound to the top level.
// Depends on cct_pkg for the result payload type.
module cct_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_valid,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input cct_pkg::t_out_item i_out_data
);

    a_reset_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input ready directly after an accepted transaction");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("stalled result changed");

    a_no_load_charging: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.charging |-> i_out_data.load_current_ma == '0)
        else $error("load current reported while charging");

endmodule

bind cell_cycle_capacity_tester cct_checker u_cct_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_chan.valid),
    .i_in_ready  (i_in_chan.ready),
    .i_out_valid (o_out_chan.valid),
    .i_out_ready (o_out_chan.ready),
    .i_out_data  (o_out_chan.data)
);
